// ===== sv/tun_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tun_pkg
// Widths and stage payload types shared by the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_W  = 32;  // input coordinate width
  localparam int EDGE_W   = 33;  // exact edge vector component
  localparam int PROD_W   = 66;  // exact product of a pair of edge components
  localparam int CROSS_W  = 67;  // exact cross product component
  localparam int MAG_W    = 66;  // cross component magnitude
  localparam int SCL_W    = 31;  // rescaled magnitude
  localparam int SQ_W     = 62;  // square of a rescaled magnitude
  localparam int SUM_W    = 64;  // sum of squares
  localparam int ROOT_W   = 32;  // integer square root of the sum
  localparam int OUT_W    = 16;  // output component width
  localparam int BLEN_W   = 7;   // bit length of a magnitude, 0 to 66
  localparam int GRP_W    = 8;   // bits per group in the leading one search
  localparam int GRP_N    = 9;   // groups covering the magnitude
  localparam int IDX_W    = 3;   // bit index inside a group

  localparam int DEF_NORMAL_FRAC_BITS = 14;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by_coord;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } tri_t;

  typedef struct packed {
    logic [CROSS_W-1:0] nx;
    logic [CROSS_W-1:0] ny;
    logic [CROSS_W-1:0] nz;
  } cross_t;

  typedef struct packed {
    logic                  degen;
    logic [2:0]            neg;
    logic [2:0][SCL_W-1:0] mag;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [SUM_W-1:0]  sum;
  } norm_t;

  typedef struct packed {
    side_t             side;
    logic [ROOT_W-1:0] root;
  } root_t;

  typedef struct packed {
    logic [OUT_W-1:0] nx;
    logic [OUT_W-1:0] ny;
    logic [OUT_W-1:0] nz;
    logic             degen;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/tun_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tun_if
// Valid/ready channels for triangle vertices and unit normal results.
// ----------------------------------------------------------------------------
interface tun_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] ax;
  logic [31:0] ay;
  logic [31:0] az;
  logic [31:0] bx;
  logic [31:0] by_coord;
  logic [31:0] bz;
  logic [31:0] cx;
  logic [31:0] cy;
  logic [31:0] cz;
  modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
  modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

interface tun_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] normal_x;
  logic [15:0] normal_y;
  logic [15:0] normal_z;
  logic        degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface
`default_nettype wire

// ===== sv/triangle_unit_normal_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_unit_normal_top
// Unit normal of a triangle from three Q16.16 vertices, as signed Q1.14.
// ----------------------------------------------------------------------------
// One triangle enters per clock while the skid register is empty, and one
// result leaves per clock while the receiver is ready. The path is 3 stages
// for edges, products and cross product, 6 for magnitude, leading one search,
// rescale, squares and sum, 32 for the bit-per-stage square root,
// NORMAL_FRAC_BITS + 3 for the bit-per-stage division with rounding and sign,
// and 1 for the output register. A skid register behind the pipeline lets
// the input keep taking items while a result waits, until a result lands in
// the skid register; the pipeline stalls as a whole only when both are full.
// A triangle whose cross product is zero returns zeros with degenerate set.
// ----------------------------------------------------------------------------
module triangle_unit_normal_top import tun_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = DEF_NORMAL_FRAC_BITS
) (
  input logic         clk,
  input logic         rst,
  tun_in_if.sink      vtx,
  tun_out_if.source   nrm
);

  logic    en;
  tri_t    tri_in;
  logic    cross_valid, norm_valid, root_valid, div_valid;
  cross_t  xprod;
  norm_t   norm;
  root_t   root;
  result_t div_res;

  logic    out_valid, skid_valid;
  result_t out_q, skid_q;

  // pipeline moves while the skid register is empty
  assign en        = ~skid_valid;
  assign vtx.ready = en;

  assign tri_in.ax       = vtx.ax;
  assign tri_in.ay       = vtx.ay;
  assign tri_in.az       = vtx.az;
  assign tri_in.bx       = vtx.bx;
  assign tri_in.by_coord = vtx.by_coord;
  assign tri_in.bz       = vtx.bz;
  assign tri_in.cx       = vtx.cx;
  assign tri_in.cy       = vtx.cy;
  assign tri_in.cz       = vtx.cz;

  tun_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vtx.valid),
    .vtx       (tri_in),
    .out_valid (cross_valid),
    .xprod     (xprod)
  );

  tun_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cross_valid),
    .xprod     (xprod),
    .out_valid (norm_valid),
    .norm      (norm)
  );

  tun_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (norm_valid),
    .norm      (norm),
    .out_valid (root_valid),
    .root      (root)
  );

  tun_div #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_valid),
    .root      (root),
    .out_valid (div_valid),
    .res       (div_res)
  );

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || nrm.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= div_valid;
      end
    end else if (en && div_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || nrm.ready) begin
      out_q <= skid_valid ? skid_q : div_res;
    end else if (en && div_valid) begin
      skid_q <= div_res;
    end
  end

  assign nrm.valid      = out_valid;
  assign nrm.normal_x   = out_q.nx;
  assign nrm.normal_y   = out_q.ny;
  assign nrm.normal_z   = out_q.nz;
  assign nrm.degenerate = out_q.degen;

  // skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while output is empty");

  // a waiting result keeps the skid item in place
  a_skid_kept: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !nrm.ready |=> skid_valid)
    else $error("skid item lost while output stalled");

  // degenerate results carry a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.degen |-> out_q.nx == '0 && out_q.ny == '0 && out_q.nz == '0)
    else $error("degenerate result with nonzero normal");

endmodule
`default_nettype wire

// ===== sv/tun_cross.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tun_cross
// Edge vectors, six exact products and the exact cross product (3 stages).
// ----------------------------------------------------------------------------
module tun_cross import tun_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  tri_t   vtx,
  output logic   out_valid,
  output cross_t xprod
);

  logic [2:0] vld;
  logic signed [EDGE_W-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [PROD_W-1:0] p0, p1, p2, p3, p4, p5;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  // edge vectors u = b - a, v = c - a
  always_ff @(posedge clk) begin
    if (en) begin
      ux <= {vtx.bx[COORD_W-1], vtx.bx} - {vtx.ax[COORD_W-1], vtx.ax};
      uy <= {vtx.by_coord[COORD_W-1], vtx.by_coord} - {vtx.ay[COORD_W-1], vtx.ay};
      uz <= {vtx.bz[COORD_W-1], vtx.bz} - {vtx.az[COORD_W-1], vtx.az};
      vx <= {vtx.cx[COORD_W-1], vtx.cx} - {vtx.ax[COORD_W-1], vtx.ax};
      vy <= {vtx.cy[COORD_W-1], vtx.cy} - {vtx.ay[COORD_W-1], vtx.ay};
      vz <= {vtx.cz[COORD_W-1], vtx.cz} - {vtx.az[COORD_W-1], vtx.az};
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= uy * vz;
      p1 <= uz * vy;
      p2 <= uz * vx;
      p3 <= ux * vz;
      p4 <= ux * vy;
      p5 <= uy * vx;
    end
  end

  // cross product components
  always_ff @(posedge clk) begin
    if (en) begin
      xprod.nx <= {p0[PROD_W-1], p0} - {p1[PROD_W-1], p1};
      xprod.ny <= {p2[PROD_W-1], p2} - {p3[PROD_W-1], p3};
      xprod.nz <= {p4[PROD_W-1], p4} - {p5[PROD_W-1], p5};
    end
  end

  assign out_valid = vld[2];

endmodule
`default_nettype wire

// ===== sv/tun_norm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tun_norm
// Magnitudes, leading one search, block rescale to 31 bits, squares and sum
// of squares (6 stages).
// ----------------------------------------------------------------------------
module tun_norm import tun_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  cross_t xprod,
  output logic   out_valid,
  output norm_t  norm
);

  logic [5:0] vld;

  logic [CROSS_W-1:0] cn [3];
  logic [CROSS_W-1:0] cneg [3];

  // stage a
  logic [MAG_W-1:0] mag_a [3];
  logic [2:0]       neg_a;
  // stage b
  logic [MAG_W-1:0] mag_b [3];
  logic [2:0]       neg_b;
  logic [GRP_N-1:0] nz_b;
  logic [IDX_W-1:0] idx_b [GRP_N];
  // stage c
  logic [MAG_W-1:0]  mag_c [3];
  logic [2:0]        neg_c;
  logic [BLEN_W-1:0] blen_c;
  logic              degen_c;
  // stage d, e
  side_t            side_d, side_e;
  logic [SQ_W-1:0]  sq_e [3];

  // combinational helpers
  logic [MAG_W-1:0]       orw;
  logic [GRP_N*GRP_W-1:0] orp;
  logic [GRP_N-1:0]       nz;
  logic [IDX_W-1:0]       idx [GRP_N];
  logic [BLEN_W-1:0]      blen;
  logic [MAG_W-1:0]       shifted [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  // stage a: sign and magnitude
  always_comb begin
    cn[0] = xprod.nx;
    cn[1] = xprod.ny;
    cn[2] = xprod.nz;
    for (int i = 0; i < 3; i++) begin
      cneg[i] = -cn[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_a[i] <= cn[i][CROSS_W-1];
        mag_a[i] <= cn[i][CROSS_W-1] ? cneg[i][MAG_W-1:0] : cn[i][MAG_W-1:0];
      end
    end
  end

  // stage b: leading one per byte group of the or of all magnitudes
  always_comb begin
    orw = mag_a[0] | mag_a[1] | mag_a[2];
    orp = {{(GRP_N*GRP_W-MAG_W){1'b0}}, orw};
    for (int g = 0; g < GRP_N; g++) begin
      nz[g]  = |orp[g*GRP_W +: GRP_W];
      idx[g] = '0;
      for (int b = 0; b < GRP_W; b++) begin
        if (orp[g*GRP_W + b]) begin
          idx[g] = IDX_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_b <= mag_a;
      neg_b <= neg_a;
      nz_b  <= nz;
      idx_b <= idx;
    end
  end

  // stage c: bit length of the largest magnitude
  always_comb begin
    blen = '0;
    for (int g = 0; g < GRP_N; g++) begin
      if (nz_b[g]) begin
        blen = BLEN_W'(g * GRP_W) + BLEN_W'(idx_b[g]) + BLEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_c   <= mag_b;
      neg_c   <= neg_b;
      blen_c  <= blen;
      degen_c <= ~|nz_b;
    end
  end

  // stage d: rescale so the largest magnitude has 31 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (blen_c > BLEN_W'(SCL_W)) begin
        shifted[i] = mag_c[i] >> (blen_c - BLEN_W'(SCL_W));
      end else begin
        shifted[i] = mag_c[i] << (BLEN_W'(SCL_W) - blen_c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d.degen <= degen_c;
      side_d.neg   <= neg_c;
      for (int i = 0; i < 3; i++) begin
        side_d.mag[i] <= shifted[i][SCL_W-1:0];
      end
    end
  end

  // stage e: squares
  always_ff @(posedge clk) begin
    if (en) begin
      side_e <= side_d;
      for (int i = 0; i < 3; i++) begin
        sq_e[i] <= SQ_W'(side_d.mag[i]) * SQ_W'(side_d.mag[i]);
      end
    end
  end

  // stage f: sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      norm.side <= side_e;
      norm.sum  <= SUM_W'(sq_e[0]) + SUM_W'(sq_e[1]) + SUM_W'(sq_e[2]);
    end
  end

  assign out_valid = vld[5];

endmodule
`default_nettype wire

// ===== sv/tun_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tun_sqrt
// Pipelined integer square root of the 64-bit sum, one result bit per stage.
// ----------------------------------------------------------------------------
module tun_sqrt import tun_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  norm_t norm,
  output logic  out_valid,
  output root_t root
);

  localparam int STEPS = ROOT_W;

  logic [SUM_W-1:0] rem_q  [STEPS];
  logic [SUM_W-1:0] res_q  [STEPS];
  side_t            side_q [STEPS];
  logic             vld_q  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);

    logic [SUM_W-1:0] rem_in, res_in, trial;
    side_t            side_in;
    logic             vld_in, ge;

    if (k == 0) begin : g_first
      assign rem_in  = norm.sum;
      assign res_in  = '0;
      assign side_in = norm.side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // trial subtract of the next root bit
    assign trial = res_in + BIT;
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? rem_in - trial : rem_in;
        res_q[k]  <= ge ? (res_in >> 1) + BIT : res_in >> 1;
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_q[STEPS-1];
  assign root.side = side_q[STEPS-1];
  assign root.root = res_q[STEPS-1][ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== sv/tun_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tun_div
// Rounded division of each magnitude by the length, one quotient bit per
// stage for all three components, then saturation and sign.
// ----------------------------------------------------------------------------
module tun_div import tun_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = DEF_NORMAL_FRAC_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  root_t   root,
  output logic    out_valid,
  output result_t res
);

  localparam int QW    = NORMAL_FRAC_BITS + 1;
  localparam int NW    = ROOT_W + NORMAL_FRAC_BITS;
  localparam int REM_W = ROOT_W + 1;
  localparam logic [QW-1:0] ONE = QW'(1) << NORMAL_FRAC_BITS;

  // prep stage
  logic [NW-1:0]     num [3];
  logic [REM_W-1:0]  rem_p [3];
  logic [QW-1:0]     low_p [3];
  logic [ROOT_W-1:0] root_p;
  side_t             side_p;
  logic              vld_p;

  // quotient stages
  logic [REM_W-1:0]  rem_q  [QW][3];
  logic [QW-1:0]     low_q  [QW][3];
  logic [QW-1:0]     quo_q  [QW][3];
  logic [ROOT_W-1:0] root_q [QW];
  side_t             side_q [QW];
  logic              vld_q  [QW];

  // final stage helpers
  logic [QW-1:0] qsat [3];
  logic [QW:0]   qext [3];
  logic [OUT_W-1:0] qout [3];
  logic          vld_o;

  // numerator with half the divisor added for rounding
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NW'(root.side.mag[i]) << NORMAL_FRAC_BITS) + NW'(root.root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else if (en) begin
      vld_p <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem_p[i] <= REM_W'(num[i] >> QW);
        low_p[i] <= num[i][QW-1:0];
      end
      root_p <= root.root;
      side_p <= root.side;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [REM_W-1:0]  rem_in  [3];
    logic [QW-1:0]     low_in  [3];
    logic [QW-1:0]     quo_in  [3];
    logic [REM_W-1:0]  trial   [3];
    logic [2:0]        ge;
    logic [ROOT_W-1:0] root_in;
    side_t             side_in;
    logic              vld_in;

    if (k == 0) begin : g_first
      assign rem_in  = rem_p;
      assign low_in  = low_p;
      assign quo_in  = '{default: '0};
      assign root_in = root_p;
      assign side_in = side_p;
      assign vld_in  = vld_p;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // shift in the next numerator bit and try the divisor
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {rem_in[i][REM_W-2:0], low_in[i][QW-1]};
        ge[i]    = trial[i] >= REM_W'(root_in);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[k][i] <= ge[i] ? trial[i] - REM_W'(root_in) : trial[i];
          low_q[k][i] <= low_in[i] << 1;
          quo_q[k][i] <= {quo_in[i][QW-2:0], ge[i]};
        end
        root_q[k] <= root_in;
        side_q[k] <= side_in;
      end
    end
  end

  // saturate, apply sign, zero degenerate results, fit to the output width
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qsat[i] = (quo_q[QW-1][i] > ONE) ? ONE : quo_q[QW-1][i];
      qext[i] = {1'b0, qsat[i]};
      if (side_q[QW-1].neg[i]) begin
        qext[i] = -qext[i];
      end
      qout[i] = side_q[QW-1].degen ? '0 : OUT_W'($signed(qext[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.nx    <= qout[0];
      res.ny    <= qout[1];
      res.nz    <= qout[2];
      res.degen <= side_q[QW-1].degen;
    end
  end

  assign out_valid = vld_o;

endmodule
`default_nettype wire

// ===== verif/tb_triangle_unit_normal_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_triangle_unit_normal_top
// Self-checking bench for the triangle unit normal pipeline: triangles are
// pushed through a bursty driver, results are taken by a stalling receiver
// and compared field by field against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_triangle_unit_normal_top import tun_pkg::*; ();

  localparam int NFB     = DEF_NORMAL_FRAC_BITS;
  localparam int LATENCY = NFB + 45;
  localparam int N_RAND  = 1400;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;

  tun_in_if  vtx ();
  tun_out_if nrm ();

  triangle_unit_normal_top #(.NORMAL_FRAC_BITS(NFB)) dut (
    .clk (clk),
    .rst (rst),
    .vtx (vtx),
    .nrm (nrm)
  );

  tri_t    pending_tris[$];
  result_t expected_normals[$];

  int     errors;
  int     n_sent;
  int     n_checked;
  int     n_degen;
  longint cycles;
  bit     stim_done;
  bit     in_taken;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // square root of a 64-bit value, bit by bit
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // predicted unit normal of one triangle
  function automatic result_t unit_normal(input tri_t t);
    logic signed [33:0]  ux, uy, uz, vx, vy, vz;
    logic signed [71:0]  cr[3];
    logic        [71:0]  mag[3];
    logic        [71:0]  biggest;
    logic        [63:0]  m[3];
    logic        [63:0]  sum, rt, q, one;
    logic        [127:0] num;
    logic        [15:0]  o[3];
    int blen, sh;
    result_t r;
    ux = 34'(signed'(t.bx))       - 34'(signed'(t.ax));
    uy = 34'(signed'(t.by_coord)) - 34'(signed'(t.ay));
    uz = 34'(signed'(t.bz))       - 34'(signed'(t.az));
    vx = 34'(signed'(t.cx))       - 34'(signed'(t.ax));
    vy = 34'(signed'(t.cy))       - 34'(signed'(t.ay));
    vz = 34'(signed'(t.cz))       - 34'(signed'(t.az));
    cr[0] = 72'(uy) * 72'(vz) - 72'(uz) * 72'(vy);
    cr[1] = 72'(uz) * 72'(vx) - 72'(ux) * 72'(vz);
    cr[2] = 72'(ux) * 72'(vy) - 72'(uy) * 72'(vx);
    biggest = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? 72'(-cr[i]) : 72'(cr[i]);
      if (mag[i] > biggest) biggest = mag[i];
    end
    r = '0;
    if (biggest == 0) begin
      r.degen = 1'b1;
      return r;
    end
    blen = 0;
    for (int i = 0; i < 72; i++) if (biggest[i]) blen = i + 1;
    sh  = blen - 31;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (sh > 0) m[i] = 64'(mag[i] >> sh);
      else        m[i] = 64'(mag[i] << (-sh));
      sum = sum + m[i] * m[i];
    end
    rt = root64(sum);
    if (rt == 0) rt = 1;
    one = 64'd1 << NFB;
    for (int i = 0; i < 3; i++) begin
      num = (128'(m[i]) << NFB) + 128'(rt >> 1);
      q   = 64'(num / 128'(rt));
      if (q > one) q = one;
      if (cr[i] < 0) q = -q;
      o[i] = q[15:0];
    end
    r.nx = o[0];
    r.ny = o[1];
    r.nz = o[2];
    return r;
  endfunction

  // coordinate with edge-heavy distribution
  function automatic coord_t rand_coord(input int range_sel);
    case (range_sel)
      0:       return coord_t'($urandom);
      1:       return coord_t'($signed($urandom_range(0, 2000)) - 1000);
      2:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return coord_t'($signed($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
    endcase
  endfunction

  function automatic tri_t make_tri(input coord_t a0, a1, a2, b0, b1, b2,
                                    c0, c1, c2);
    tri_t t;
    t.ax = a0; t.ay = a1; t.az = a2;
    t.bx = b0; t.by_coord = b1; t.bz = b2;
    t.cx = c0; t.cy = c1; t.cz = c2;
    return t;
  endfunction

  // append one triangle to the pending queue
  task automatic add_tri(input tri_t t);
    pending_tris.insert(pending_tris.size(), t);
  endtask

  // stimulus
  initial begin
    tri_t t;
    int   sel;
    coord_t mx, mn;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    // axis-aligned triangles, both windings
    add_tri(make_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
    add_tri(make_tri(0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0));
    add_tri(make_tri(0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000));
    add_tri(make_tri(0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0));
    // degenerate: all equal, collinear, zero
    add_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_tri(make_tri(5, 6, 7, 5, 6, 7, 5, 6, 7));
    add_tri(make_tri(0, 0, 0, 1, 2, 3, 2, 4, 6));
    add_tri(make_tri(mn, mn, mn, mx, mx, mx, mn, mn, mn));
    // extremes of the coordinate range
    add_tri(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn));
    add_tri(make_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx));
    add_tri(make_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx));
    add_tri(make_tri(mx, mn, 0, mn, mx, mx, mx, mx, mn));
    // tiny components next to a huge one
    add_tri(make_tri(0, 0, 0, mx, 0, 0, 1, mx, 0));
    add_tri(make_tri(0, 0, 0, mx, 1, 0, mn, 0, 1));
    // smallest nonzero cross products
    add_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    add_tri(make_tri(0, 0, 0, 1, 1, 1, 1, 1, 2));
    add_tri(make_tri(-1, -1, -1, 0, -1, -1, -1, -1, 0));
    // equal components, rounding
    add_tri(make_tri(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000));
    add_tri(make_tri(0, 0, 0, 3, 0, 4, 0, 5, 0));
    add_tri(make_tri(mx, mx, mx, 0, 0, 0, mn, mn, mx));
    for (int i = 0; i < N_RAND; i++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        // collinear: c = a + k*(b - a)
        t.ax = rand_coord(3); t.ay = rand_coord(3); t.az = rand_coord(3);
        t.bx = rand_coord(1); t.by_coord = rand_coord(1); t.bz = rand_coord(1);
        t.cx = t.ax + 2 * (t.bx - t.ax);
        t.cy = t.ay + 2 * (t.by_coord - t.ay);
        t.cz = t.az + 2 * (t.bz - t.az);
      end else begin
        sel = $urandom_range(0, 3);
        t = make_tri(rand_coord(sel), rand_coord(sel), rand_coord(sel),
                     rand_coord(sel), rand_coord(sel), rand_coord(sel),
                     rand_coord(sel), rand_coord(sel), rand_coord(sel));
      end
      add_tri(t);
    end
  end

  // reset and end of run
  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (stim_done && expected_normals.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d triangles sent, %0d normals checked, %0d degenerate",
             n_sent, n_checked, n_degen);
    $display("covered extreme coordinates, collinear sets and long output stalls");
    if (errors == 0 && expected_normals.size() == 0)
      $display("triangle_unit_normal_top regression: pass");
    else
      $display("triangle_unit_normal_top regression: fail");
    $finish;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("triangle_unit_normal_top regression: fail");
      $finish;
    end
  end

  initial begin
    cycles    = 0;
    errors    = 0;
    n_sent    = 0;
    n_checked = 0;
    n_degen   = 0;
    stim_done = 1'b0;
    vtx.valid = 1'b0;
    {vtx.ax, vtx.ay, vtx.az, vtx.bx, vtx.by_coord, vtx.bz,
     vtx.cx, vtx.cy, vtx.cz} = '0;
    nrm.ready = 1'b0;
  end

  // input acceptance, taken at the rising edge
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst && vtx.valid && vtx.ready) begin
      in_taken = 1'b1;
      expected_normals.insert(expected_normals.size(),
                              unit_normal(pending_tris.pop_front()));
      n_sent++;
    end
  end

  // driver: bursts of items with gaps
  int burst_left;
  int gap_left;
  initial begin
    burst_left = 0;
    gap_left   = 0;
  end

  always @(negedge clk) begin
    tri_t t;
    if (!rst) begin
      if (vtx.valid && !in_taken) begin
        // item still offered
      end else if (gap_left > 0) begin
        gap_left--;
        vtx.valid <= 1'b0;
      end else if (pending_tris.size() > 0) begin
        t = pending_tris[0];
        vtx.valid    <= 1'b1;
        vtx.ax       <= t.ax;       vtx.ay <= t.ay; vtx.az <= t.az;
        vtx.bx       <= t.bx;       vtx.by_coord <= t.by_coord;
        vtx.bz       <= t.bz;
        vtx.cx       <= t.cx;       vtx.cy <= t.cy; vtx.cz <= t.cz;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 8);
        end
      end else begin
        vtx.valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // receiver stall pattern, with one long hold-off early on
  int stall_phase;
  int hold_count;
  initial begin
    stall_phase = 0;
    hold_count  = 0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (n_sent > 200 && hold_count < 300) begin
        hold_count++;
        nrm.ready <= 1'b0;
      end else begin
        stall_phase = (stall_phase + 1) % 256;
        if (stall_phase < 64) nrm.ready <= 1'b1;
        else nrm.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // monitor: compare each accepted normal with the oldest prediction
  always @(posedge clk) begin
    result_t exp_n;
    if (!rst && nrm.valid && nrm.ready) begin
      if (expected_normals.size() == 0) begin
        errors++;
        $display("%0t unexpected normal %h %h %h degen %b", $time,
                 nrm.normal_x, nrm.normal_y, nrm.normal_z, nrm.degenerate);
      end else begin
        exp_n = expected_normals.pop_front();
        n_checked++;
        if (exp_n.degen) n_degen++;
        if (nrm.normal_x !== exp_n.nx || nrm.normal_y !== exp_n.ny ||
            nrm.normal_z !== exp_n.nz || nrm.degenerate !== exp_n.degen) begin
          errors++;
          $display("%0t mismatch expected %h %h %h degen %b actual %h %h %h degen %b",
                   $time, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.degen,
                   nrm.normal_x, nrm.normal_y, nrm.normal_z, nrm.degenerate);
        end
      end
    end
  end

endmodule
`default_nettype wire
